// File: rtl/plist_pkg.sv
// shared types and codes for the positional list block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package plist_pkg;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_DUMP   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_EMPTY   = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_LD,
        S_RESP
    } state_t;

endpackage

// File: rtl/plist_store.sv
// entry store of the positional list: one write port, one registered read port
// depends on plist_pkg for the data width
`timescale 1ns / 1ps

module plist_store
    import plist_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/positional_list_insert_delete.sv
// positional list with insert, delete and dump, entries kept in an indexed store
// insert moves entries from the end down to the position up one place, each one via
//   S_INS_CHK and S_INS_WR; delete moves later entries down via S_DEL_CHK and S_DEL_WR;
//   a rejected item goes to S_RESP; moves use the store's ports and the shared index unit
// dump: S_DUMP_RD, S_DUMP_LD and S_RESP per entry, S_RESP held until m_tready; one item in flight at a time
// reset (aresetn low, synchronous): sequencer idle, length zero, store contents kept
`timescale 1ns / 1ps

module positional_list_insert_delete
    import plist_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], value_in[39:8]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value_out[31:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    state_t             state_reg,  state_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic [LEN_W-1:0]   idx_reg,    idx_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [DATA_W-1:0]  val_reg,    val_next;
    logic               dump_reg,   dump_next;
    status_t            status_reg, status_next;
    logic [DATA_W-1:0]  vout_reg,   vout_next;
    logic               last_reg,   last_next;

    logic [LEN_W-1:0]   idx_step;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [DATA_W-1:0]  mem_rdata;

    func_t              in_func;
    logic [POS_W-1:0]   in_pos;
    logic [DATA_W-1:0]  in_val;

    assign in_func = func_t'(s_tuser);
    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_val  = s_tdata[POS_W +: DATA_W];

    // shared index unit: walks down while opening a gap, up otherwise
    assign idx_step = (state_reg == S_INS_CHK || state_reg == S_INS_WR)
                    ? idx_reg - LEN_W'(1) : idx_reg + LEN_W'(1);

    plist_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        length_next = length_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        dump_next   = dump_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        last_next   = last_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    vout_next = '0;
                    last_next = 1'b1;
                    dump_next = 1'b0;
                    pos_next  = in_pos;
                    val_next  = in_val;
                    case (in_func)
                        FUNC_INSERT: begin
                            if (in_pos > POS_W'(length_reg)) begin
                                status_next = STATUS_BAD_POS;
                                state_next  = S_RESP;
                            end else if (length_reg == LEN_W'(CAPACITY)) begin
                                status_next = STATUS_FULL;
                                state_next  = S_RESP;
                            end else begin
                                idx_next   = length_reg;
                                state_next = S_INS_CHK;
                            end
                        end
                        FUNC_DELETE: begin
                            if (length_reg == '0) begin
                                status_next = STATUS_EMPTY;
                                state_next  = S_RESP;
                            end else if (in_pos >= POS_W'(length_reg)) begin
                                status_next = STATUS_BAD_POS;
                                state_next  = S_RESP;
                            end else begin
                                idx_next   = in_pos[LEN_W-1:0];
                                state_next = S_DEL_CHK;
                            end
                        end
                        FUNC_DUMP: begin
                            if (length_reg == '0) begin
                                status_next = STATUS_EMPTY;
                                state_next  = S_RESP;
                            end else begin
                                dump_next  = 1'b1;
                                idx_next   = '0;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_CHK: begin
                if (POS_W'(idx_reg) > pos_reg) begin
                    state_next = S_INS_WR;
                end else begin
                    length_next = length_reg + LEN_W'(1);
                    status_next = STATUS_OK;
                    state_next  = S_RESP;
                end
            end
            S_INS_WR: begin
                idx_next   = idx_step;
                state_next = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if (idx_step < length_reg) begin
                    state_next = S_DEL_WR;
                end else begin
                    length_next = length_reg - LEN_W'(1);
                    status_next = STATUS_OK;
                    state_next  = S_RESP;
                end
            end
            S_DEL_WR: begin
                idx_next   = idx_step;
                state_next = S_DEL_CHK;
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_LD;
            end
            S_DUMP_LD: begin
                status_next = STATUS_OK;
                vout_next   = mem_rdata;
                last_next   = (idx_step == length_reg);
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (m_tready) begin
                    if (dump_reg && !last_reg) begin
                        idx_next   = idx_step;
                        state_next = S_DUMP_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg[ADDR_W-1:0];
        mem_raddr = idx_step[ADDR_W-1:0];
        mem_wdata = mem_rdata;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_INS_CHK: begin
                // the gap has reached the insert position
                if (!(POS_W'(idx_reg) > pos_reg)) begin
                    mem_we    = 1'b1;
                    mem_wdata = val_reg;
                end
            end
            S_INS_WR, S_DEL_WR: begin
                mem_we = 1'b1;
            end
            S_DUMP_RD: begin
                mem_raddr = idx_reg[ADDR_W-1:0];
            end
            S_RESP: begin
                m_tvalid = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            length_reg <= '0;
        end else begin
            state_reg  <= state_next;
            length_reg <= length_next;
        end
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        dump_reg   <= dump_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        last_reg   <= last_next;
    end

    assign m_tdata = vout_reg;
    assign m_tuser = status_reg;
    assign m_tlast = last_reg;

endmodule

// File: rtl/plist_checker.sv
// port-level checks for positional_list_insert_delete, attached by bind
// depends on plist_pkg for status codes and on the top level's port names
`timescale 1ns / 1ps

module plist_checker
    import plist_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // one item at a time: no intake while a result is pending
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // an error status is a single word with zero data
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tlast && m_tdata == '0)
        else $error("error result not a lone zero word");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind positional_list_insert_delete plist_checker u_plist_checker (.*);

// File: sim/tb_positional_list_insert_delete.sv
// self-checking testbench for positional_list_insert_delete: a shadow list predicts every
// result word; directed table first, then fill, stall, drain and random phases
// depends on rtl/plist_pkg.sv and rtl/positional_list_insert_delete.sv
`timescale 1ns / 1ps

module tb_positional_list_insert_delete;
    import plist_pkg::*;

    localparam int LIST_CAP    = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 2 * LIST_CAP + 8;

    typedef struct packed {
        status_t     st;
        logic [31:0] vout;
        logic        lst;
    } res_word_t;

    typedef struct packed {
        func_t       f;
        logic [7:0]  pos;
        logic [31:0] val;
        logic        typed;
        status_t     st;
    } dir_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // position[7:0], value_in[39:8]
    logic [1:0]  s_tuser  = '0;  // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // value_out[31:0]
    logic [1:0]  m_tuser;        // status[1:0]
    logic        m_tlast;

    positional_list_insert_delete #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // shadow copy of the list
    logic [31:0] shadow_entries [0:LIST_CAP-1];
    int          shadow_len = 0;
    res_word_t   pending_words [$];
    dir_row_t    dir_tab [$];

    int errors = 0;
    int quiet  = 0;
    bit s_idle_en = 1'b1;
    bit m_idle_en = 1'b1;
    bit hold_pending = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic res_word_t status_word(status_t st, logic [31:0] v, logic l);
        res_word_t w;
        w.st   = st;
        w.vout = v;
        w.lst  = l;
        return w;
    endfunction

    task automatic list_apply(input func_t f, input logic [7:0] p, input logic [31:0] v);
        int i;
        case (f)
            FUNC_INSERT: begin
                // position check takes precedence over the full check
                if (p > shadow_len) begin
                    pending_words.push_back(status_word(STATUS_BAD_POS, 32'd0, 1'b1));
                end else if (shadow_len >= LIST_CAP) begin
                    pending_words.push_back(status_word(STATUS_FULL, 32'd0, 1'b1));
                end else begin
                    for (i = shadow_len; i > p; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[p] = v;
                    shadow_len++;
                    pending_words.push_back(status_word(STATUS_OK, 32'd0, 1'b1));
                end
            end
            FUNC_DELETE: begin
                if (shadow_len == 0) begin
                    pending_words.push_back(status_word(STATUS_EMPTY, 32'd0, 1'b1));
                end else if (p >= shadow_len) begin
                    pending_words.push_back(status_word(STATUS_BAD_POS, 32'd0, 1'b1));
                end else begin
                    for (i = p; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_len--;
                    pending_words.push_back(status_word(STATUS_OK, 32'd0, 1'b1));
                end
            end
            FUNC_DUMP: begin
                if (shadow_len == 0) begin
                    pending_words.push_back(status_word(STATUS_EMPTY, 32'd0, 1'b1));
                end else begin
                    for (i = 0; i < shadow_len; i++)
                        pending_words.push_back(status_word(STATUS_OK, shadow_entries[i],
                                                            (i == shadow_len - 1)));
                end
            end
            default: ;
        endcase
    endtask

    // called at a rising edge; returns at the edge where the word is taken
    task automatic offer(input func_t f, input logic [7:0] p, input logic [31:0] v);
        int gap;
        gap = s_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {v, p};
        do @(posedge aclk); while (!s_tready);
        list_apply(f, p, v);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    task automatic random_item(input int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            if ($urandom_range(0, 9) != 0)
                offer(FUNC_INSERT, 8'($urandom_range(0, shadow_len)), $urandom);
            else
                offer(FUNC_INSERT, 8'($urandom_range(0, 255)), $urandom);
        end else if (r < 92) begin
            if (shadow_len > 0 && $urandom_range(0, 9) != 0)
                offer(FUNC_DELETE, 8'($urandom_range(0, shadow_len - 1)), $urandom);
            else
                offer(FUNC_DELETE, 8'($urandom_range(0, 255)), $urandom);
        end else if (r < 97) begin
            offer(FUNC_DUMP, 8'($urandom_range(0, 255)), $urandom);
        end else begin
            offer(FUNC_NONE, 8'($urandom_range(0, 255)), $urandom);
        end
    endtask

    // receiver: random back-pressure per word, one long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (m_idle_en) begin
                gap = $urandom_range(0, 4);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : result_check
        res_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word: status %0d value %h last %b",
                         $time, m_tuser, m_tdata, m_tlast);
                errors++;
            end else begin
                w = pending_words.pop_front();
                if (m_tuser !== w.st) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, w.st, m_tuser);
                    errors++;
                end
                if (m_tdata !== w.vout) begin
                    $display("%0t: value mismatch: expected %h actual %h",
                             $time, w.vout, m_tdata);
                    errors++;
                end
                if (m_tlast !== w.lst) begin
                    $display("%0t: last mismatch: expected %b actual %b",
                             $time, w.lst, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            quiet <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial begin
        wait (quiet >= STALL_LIMIT);
        $display("** positional_list_insert_delete: FAILED **");
        $finish;
    end

    initial begin
        int seg;
        int k;
        int pcts [4];
        pcts = '{75, 55, 35, 60};

        // directed rows: typed ones carry status, with value zero and last set
        dir_tab.push_back('{FUNC_DUMP,   8'd0,   32'd0,          1'b1, STATUS_EMPTY});
        dir_tab.push_back('{FUNC_DELETE, 8'd0,   32'd0,          1'b1, STATUS_EMPTY});
        dir_tab.push_back('{FUNC_DELETE, 8'hFF,  32'hFFFF_FFFF,  1'b1, STATUS_EMPTY});
        dir_tab.push_back('{FUNC_INSERT, 8'd1,   32'h1234_5678,  1'b1, STATUS_BAD_POS});
        dir_tab.push_back('{FUNC_INSERT, 8'hFF,  32'hFFFF_FFFF,  1'b1, STATUS_BAD_POS});
        dir_tab.push_back('{FUNC_INSERT, 8'd0,   32'h7FFF_FFFF,  1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_INSERT, 8'd0,   32'h8000_0000,  1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_INSERT, 8'd2,   32'd0,          1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_INSERT, 8'd1,   32'hFFFF_FFFF,  1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_INSERT, 8'd5,   32'd1,          1'b1, STATUS_BAD_POS});
        dir_tab.push_back('{FUNC_DUMP,   8'hFF,  32'hFFFF_FFFF,  1'b0, STATUS_OK});
        dir_tab.push_back('{FUNC_NONE,   8'hFF,  32'hFFFF_FFFF,  1'b0, STATUS_OK});
        dir_tab.push_back('{FUNC_DELETE, 8'd4,   32'd0,          1'b1, STATUS_BAD_POS});
        dir_tab.push_back('{FUNC_DELETE, 8'hFF,  32'd0,          1'b1, STATUS_BAD_POS});
        dir_tab.push_back('{FUNC_DELETE, 8'd3,   32'd0,          1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_DELETE, 8'd0,   32'd0,          1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_DUMP,   8'd0,   32'd0,          1'b0, STATUS_OK});
        dir_tab.push_back('{FUNC_DELETE, 8'd0,   32'd0,          1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_DELETE, 8'd0,   32'd0,          1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_DUMP,   8'd0,   32'd0,          1'b1, STATUS_EMPTY});
        dir_tab.push_back('{FUNC_INSERT, 8'd0,   32'h5555_AAAA,  1'b1, STATUS_OK});
        dir_tab.push_back('{FUNC_DUMP,   8'd0,   32'd0,          1'b0, STATUS_OK});
        dir_tab.push_back('{FUNC_NONE,   8'd0,   32'd0,          1'b0, STATUS_OK});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < dir_tab.size(); k++) begin
            offer(dir_tab[k].f, dir_tab[k].pos, dir_tab[k].val);
            if (dir_tab[k].typed) begin
                void'(pending_words.pop_back());
                pending_words.push_back(status_word(dir_tab[k].st, 32'd0, 1'b1));
            end
        end

        // fill to capacity, then hit the full and past-the-end checks
        while (shadow_len < LIST_CAP)
            offer(FUNC_INSERT, 8'($urandom_range(0, shadow_len)), $urandom);
        offer(FUNC_INSERT, 8'(LIST_CAP + 1), $urandom);
        offer(FUNC_INSERT, 8'(LIST_CAP), $urandom);
        offer(FUNC_INSERT, 8'd0, $urandom);

        // receiver stalls mid dump while the sender keeps offering
        hold_pending = 1'b1;
        offer(FUNC_DUMP, 8'd0, 32'd0);
        offer(FUNC_INSERT, 8'd0, $urandom);
        offer(FUNC_DELETE, 8'd200, $urandom);
        offer(FUNC_DELETE, 8'(LIST_CAP - 1), $urandom);
        wait_drained();

        while (shadow_len > 0)
            offer(FUNC_DELETE, 8'($urandom_range(0, shadow_len - 1)), $urandom);
        offer(FUNC_DELETE, 8'($urandom_range(0, 255)), $urandom);

        for (seg = 0; seg < 4; seg++) begin
            s_idle_en = (seg != 2) ? 1'b1 : 1'b0;
            m_idle_en = (seg != 2 && seg != 3) ? 1'b1 : 1'b0;
            if (seg == 3)
                s_idle_en = 1'($urandom_range(0, 1));
            for (k = 0; k < 38; k++)
                random_item(pcts[seg]);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("** positional_list_insert_delete: PASSED **");
        else
            $display("** positional_list_insert_delete: FAILED **");
        $finish;
    end

endmodule
